@@ sv/tt_pkg.sv @@
package tt_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int ADDR_W      = 11;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam logic [7:0] COLOR_RST = 8'h07;
    localparam logic [15:0] CELL_RST = 16'h0720;

    // byte codes
    localparam logic [7:0] B_ESC   = 8'h1B;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_LBRK  = 8'h5B;
    localparam logic [7:0] B_SEMI  = 8'h3B;
    localparam logic [7:0] B_ZERO  = 8'h30;
    localparam logic [7:0] B_NINE  = 8'h39;
    localparam logic [7:0] B_PLO   = 8'h30;
    localparam logic [7:0] B_PHI   = 8'h3F;
    localparam logic [7:0] B_ILO   = 8'h20;
    localparam logic [7:0] B_IHI   = 8'h2F;
    localparam logic [7:0] B_FLO   = 8'h40;
    localparam logic [7:0] B_FHI   = 8'h7F;

    localparam logic [7:0] F_H = 8'h48;
    localparam logic [7:0] F_F = 8'h66;
    localparam logic [7:0] F_A = 8'h41;
    localparam logic [7:0] F_B = 8'h42;
    localparam logic [7:0] F_C = 8'h43;
    localparam logic [7:0] F_D = 8'h44;
    localparam logic [7:0] F_E = 8'h45;
    localparam logic [7:0] F_FU = 8'h46;
    localparam logic [7:0] F_G = 8'h47;
    localparam logic [7:0] F_J = 8'h4A;
    localparam logic [7:0] F_K = 8'h4B;
    localparam logic [7:0] F_S = 8'h53;
    localparam logic [7:0] F_T = 8'h54;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data_byte;
        logic [ADDR_W-1:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0]      read_entry;
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
        logic             in_sequence;
    } out_item_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_READ  = 3'd1,
        OP_WRITE = 3'd2,
        OP_FILL  = 3'd3,
        OP_COPY  = 3'd4
    } op_t;

    // controller to datapath
    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr;
        logic [15:0]       wdata;
    } mem_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [15:0] rdata;
    } mem_stat_t;

endpackage

@@ sv/tt_screen.sv @@
module tt_screen #(
    parameter int CELLS = 2000
) (
    input  logic             aclk,
    input  tt_pkg::mem_cmd_t cmd,
    output tt_pkg::mem_stat_t stat
);
    import tt_pkg::*;

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;
    logic [15:0] copy_reg;
    logic        copy_reg_v;

    // single write port, single registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[cmd.raddr];
        if (cmd.op == OP_WRITE || cmd.op == OP_FILL) begin
            mem[cmd.waddr] <= cmd.wdata;
        end else if (cmd.op == OP_COPY) begin
            mem[cmd.waddr] <= rdata_reg;
        end
    end

    assign copy_reg   = rdata_reg;
    assign copy_reg_v = 1'b1;
    assign stat.rdata = copy_reg_v ? copy_reg : 16'h0;

endmodule

@@ sv/tt_ctrl.sv @@
module tt_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tt_pkg::in_item_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tt_pkg::out_item_t  m_data,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    output tt_pkg::mem_cmd_t   cmd,
    input  tt_pkg::mem_stat_t  stat
);
    import tt_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW = COL_W;
    localparam int RW = ROW_W;
    localparam int AW = ADDR_W;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_RDW   = 9'b000001000,
        S_FILL  = 9'b000010000,
        S_COPYR = 9'b000100000,
        S_COPYW = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_INIT  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2,
        PH_INTER = 2'd3
    } phase_t;

    state_t       state_reg, state_next;
    phase_t       phase_reg, phase_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [15:0]  p0_reg, p0_next, p1_reg, p1_next;
    logic [1:0]   pidx_reg, pidx_next;
    logic [7:0]   color_reg;
    logic [AW-1:0] ptr_reg, ptr_next, end_reg, end_next;
    logic [AW-1:0] src_reg, src_next;
    logic         down_reg, down_next;
    logic [AW-1:0] fend_reg, fend_next;   // fill range after a copy
    logic [AW-1:0] fbeg_reg, fbeg_next;
    logic         pend_reg, pend_next;    // fill pending after copy
    logic         mv_reg, mv_next;
    out_item_t    mo_reg, mo_next;

    // config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= COLOR_RST;
        end else if (cfg_we) begin
            color_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            phase_reg <= PH_TEXT;
            col_reg   <= '0;
            row_reg   <= '0;
            p0_reg    <= '0;
            p1_reg    <= '0;
            pidx_reg  <= '0;
            ptr_reg   <= '0;
            end_reg   <= '0;
            src_reg   <= '0;
            down_reg  <= 1'b0;
            fend_reg  <= '0;
            fbeg_reg  <= '0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            pidx_reg  <= pidx_next;
            ptr_reg   <= ptr_next;
            end_reg   <= end_next;
            src_reg   <= src_next;
            down_reg  <= down_next;
            fend_reg  <= fend_next;
            fbeg_reg  <= fbeg_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        mo_reg <= mo_next;
    end

    assign s_ready = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid = mv_reg;
    assign m_data  = mo_reg;

    // helpers on widened values
    logic [17:0] n_w, p1n_w;
    logic [17:0] row_w, col_w;
    logic [AW-1:0] cur_a, line_a;
    logic [7:0]  b;
    logic [16:0] dig;
    logic [20:0] acc;
    logic [17:0] nrows;

    always_comb begin
        n_w   = (p0_reg == 16'd0) ? 18'd1 : {2'b0, p0_reg};
        p1n_w = (p1_reg == 16'd0) ? 18'd1 : {2'b0, p1_reg};
        row_w = {{(18-RW){1'b0}}, row_reg};
        col_w = {{(18-CW){1'b0}}, col_reg};
        cur_a = AW'(row_reg * COLUMNS) + AW'(col_reg);
        line_a = AW'(row_reg * COLUMNS);
        b = s_data.data_byte;
        nrows = (n_w > 18'(ROWS)) ? 18'(ROWS) : n_w;
    end

    logic [17:0] shift_amt;
    assign shift_amt = nrows * 18'(COLUMNS);

    always_comb begin
        logic do_text;
        logic do_exec;
        logic [15:0] pv;
        state_next = state_reg;
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        p0_next    = p0_reg;
        p1_next    = p1_reg;
        pidx_next  = pidx_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        src_next   = src_reg;
        down_next  = down_reg;
        fend_next  = fend_reg;
        fbeg_next  = fbeg_reg;
        pend_next  = pend_reg;
        mv_next    = mv_reg;
        mo_next    = mo_reg;
        cmd.op     = OP_NONE;
        cmd.waddr  = ptr_reg;
        cmd.raddr  = s_data.cell_address;
        cmd.wdata  = 16'h0;
        do_text    = 1'b0;
        do_exec    = 1'b0;
        pv         = '0;
        acc        = '0;
        dig        = '0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            // clear pass after reset
            S_INIT: begin
                cmd.op    = OP_FILL;
                cmd.waddr = ptr_reg;
                cmd.wdata = CELL_RST;
                if (ptr_reg == AW'(CELLS - 1)) begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_CLR: begin
                state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_data.kind) begin
                        cmd.op    = OP_READ;
                        state_next = S_RD;
                        src_next  = s_data.cell_address;
                    end else begin
                        state_next = S_OUT;
                        priority if (phase_reg == PH_TEXT) begin
                            do_text = 1'b1;
                        end else if (phase_reg == PH_ESC) begin
                            if (b == B_LBRK) begin
                                phase_next = PH_PARAM;
                                p0_next = '0;
                                p1_next = '0;
                                pidx_next = '0;
                            end else begin
                                phase_next = PH_TEXT;
                                do_text = 1'b1;
                            end
                        end else if (phase_reg == PH_PARAM && b >= B_PLO && b <= B_PHI) begin
                            if (b <= B_NINE) begin
                                if (pidx_reg < 2'd2) begin
                                    pv  = pidx_reg[0] ? p1_reg : p0_reg;
                                    dig = 17'(b - B_ZERO);
                                    acc = 21'(pv) * 21'd10 + 21'(dig);
                                    if (acc > 21'd65535) begin
                                        pv = 16'hFFFF;
                                    end else begin
                                        pv = acc[15:0];
                                    end
                                    if (pidx_reg[0]) p1_next = pv;
                                    else p0_next = pv;
                                end
                            end else if (b == B_SEMI && pidx_reg < 2'd2) begin
                                pidx_next = pidx_reg + 1'b1;
                            end
                        end else if (b >= B_ILO && b <= B_IHI) begin
                            phase_next = PH_INTER;
                        end else if (b >= B_FLO && b <= B_FHI) begin
                            phase_next = PH_TEXT;
                            do_exec = 1'b1;
                        end else begin
                            phase_next = PH_TEXT;
                            do_text = 1'b1;
                        end

                        if (do_text) begin
                            if (b == B_ESC) begin
                                phase_next = PH_ESC;
                            end else if (b == B_LF) begin
                                col_next = '0;
                                if (row_reg == RW'(ROWS - 1)) begin
                                    down_next = 1'b0;
                                    ptr_next  = '0;
                                    src_next  = AW'(COLUMNS);
                                    end_next  = AW'(CELLS - COLUMNS - 1);
                                    fbeg_next = AW'(CELLS - COLUMNS);
                                    fend_next = AW'(CELLS - 1);
                                    pend_next = 1'b1;
                                    state_next = S_COPYR;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                end
                            end else begin
                                cmd.op    = OP_WRITE;
                                cmd.waddr = cur_a;
                                cmd.wdata = {color_reg, b};
                                if (col_reg == CW'(COLUMNS - 1)) begin
                                    col_next = '0;
                                    if (row_reg == RW'(ROWS - 1)) begin
                                        down_next = 1'b0;
                                        ptr_next  = '0;
                                        src_next  = AW'(COLUMNS);
                                        end_next  = AW'(CELLS - COLUMNS - 1);
                                        fbeg_next = AW'(CELLS - COLUMNS);
                                        fend_next = AW'(CELLS - 1);
                                        pend_next = 1'b1;
                                        state_next = S_COPYR;
                                    end else begin
                                        row_next = row_reg + 1'b1;
                                    end
                                end else begin
                                    col_next = col_reg + 1'b1;
                                end
                            end
                        end

                        if (do_exec) begin
                            unique case (b)
                                F_H, F_F: begin
                                    row_next = (n_w > 18'(ROWS)) ? RW'(ROWS - 1)
                                                                : RW'(n_w - 18'd1);
                                    col_next = (p1n_w > 18'(COLUMNS)) ? CW'(COLUMNS - 1)
                                                                     : CW'(p1n_w - 18'd1);
                                end
                                F_A: row_next = (n_w > row_w) ? '0 : RW'(row_w - n_w);
                                F_B: row_next = (row_w + n_w > 18'(ROWS - 1))
                                              ? RW'(ROWS - 1) : RW'(row_w + n_w);
                                F_C: col_next = (col_w + n_w > 18'(COLUMNS - 1))
                                              ? CW'(COLUMNS - 1) : CW'(col_w + n_w);
                                F_D: col_next = (n_w > col_w) ? '0 : CW'(col_w - n_w);
                                F_E: begin
                                    row_next = (row_w + n_w > 18'(ROWS - 1))
                                             ? RW'(ROWS - 1) : RW'(row_w + n_w);
                                    col_next = '0;
                                end
                                F_FU: begin
                                    row_next = (n_w > row_w) ? '0 : RW'(row_w - n_w);
                                    col_next = '0;
                                end
                                F_G: col_next = (n_w > 18'(COLUMNS)) ? CW'(COLUMNS - 1)
                                              : CW'(n_w - 18'd1);
                                F_J: begin
                                    if (p0_reg == 16'd0) begin
                                        ptr_next = cur_a; end_next = AW'(CELLS - 1);
                                        state_next = S_FILL;
                                    end else if (p0_reg == 16'd1) begin
                                        ptr_next = '0; end_next = cur_a;
                                        state_next = S_FILL;
                                    end else if (p0_reg == 16'd2 || p0_reg == 16'd3) begin
                                        ptr_next = '0; end_next = AW'(CELLS - 1);
                                        state_next = S_FILL;
                                    end
                                end
                                F_K: begin
                                    if (p0_reg == 16'd0) begin
                                        ptr_next = cur_a;
                                        end_next = line_a + AW'(COLUMNS - 1);
                                        state_next = S_FILL;
                                    end else if (p0_reg == 16'd1) begin
                                        ptr_next = line_a; end_next = cur_a;
                                        state_next = S_FILL;
                                    end else if (p0_reg == 16'd2) begin
                                        ptr_next = line_a;
                                        end_next = line_a + AW'(COLUMNS - 1);
                                        state_next = S_FILL;
                                    end
                                end
                                F_S: begin
                                    down_next = 1'b0;
                                    pend_next = 1'b1;
                                    fbeg_next = AW'(18'(CELLS) - shift_amt);
                                    fend_next = AW'(CELLS - 1);
                                    if (nrows == 18'(ROWS)) begin
                                        ptr_next = fbeg_next; end_next = fend_next;
                                        pend_next = 1'b0;
                                        state_next = S_FILL;
                                    end else begin
                                        ptr_next = '0;
                                        src_next = AW'(shift_amt);
                                        end_next = AW'(18'(CELLS) - shift_amt - 18'd1);
                                        state_next = S_COPYR;
                                    end
                                end
                                F_T: begin
                                    down_next = 1'b1;
                                    pend_next = 1'b1;
                                    fbeg_next = '0;
                                    fend_next = AW'(shift_amt - 18'd1);
                                    if (nrows == 18'(ROWS)) begin
                                        ptr_next = '0; end_next = fend_next;
                                        pend_next = 1'b0;
                                        state_next = S_FILL;
                                    end else begin
                                        ptr_next = AW'(CELLS - 1);
                                        src_next = AW'(18'(CELLS) - shift_amt - 18'd1);
                                        end_next = AW'(shift_amt);
                                        state_next = S_COPYR;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        mo_next.read_entry = '0;
                    end
                end
            end
            // read data returns next cycle, hold the captured address
            S_RD: begin
                cmd.raddr  = src_reg;
                state_next = S_RDW;
            end
            S_RDW: begin
                mo_next.read_entry = (src_reg < AW'(CELLS)) ? stat.rdata : 16'h0;
                state_next = S_OUT;
            end
            S_FILL: begin
                cmd.op    = OP_FILL;
                cmd.waddr = ptr_reg;
                if (ptr_reg == end_reg) begin
                    state_next = S_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            // copy: read source, then write destination
            S_COPYR: begin
                cmd.raddr  = src_reg;
                state_next = S_COPYW;
            end
            S_COPYW: begin
                cmd.op    = OP_COPY;
                cmd.waddr = ptr_reg;
                cmd.raddr = src_reg;
                if (ptr_reg == end_reg) begin
                    if (pend_reg) begin
                        ptr_next = fbeg_reg;
                        end_next = fend_reg;
                        pend_next = 1'b0;
                        state_next = S_FILL;
                    end else begin
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_COPYR;
                    if (down_reg) begin
                        ptr_next = ptr_reg - 1'b1;
                        src_next = src_reg - 1'b1;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                        src_next = src_reg + 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    mo_next.cursor_column = col_reg;
                    mo_next.cursor_row    = row_reg;
                    mo_next.in_sequence   = (phase_reg != PH_TEXT);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ sv/text_terminal_with_csi_cursor_control.sv @@
// text byte: S_IDLE, S_OUT; cell read: S_IDLE, S_RD, S_RDW, S_OUT; then m_valid
// erase: one cell per cycle; scroll: copy cells via S_COPYR/S_COPYW, then clear
// one item at a time: s_ready is high only in S_IDLE with no result pending
// reset: synchronous active-low aresetn; a clearing pass over all ROWS*COLUMNS
// cells writes grey spaces before the first request is taken
module text_terminal_with_csi_cursor_control #(
    parameter int COLUMNS = tt_pkg::COLUMNS_DEF,
    parameter int ROWS    = tt_pkg::ROWS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tt_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tt_pkg::out_item_t m_data,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata
);
    import tt_pkg::*;

    mem_cmd_t  cmd;
    mem_stat_t stat;

    tt_ctrl #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_we, .cfg_wdata,
        .cmd, .stat
    );

    tt_screen #(.CELLS(COLUMNS * ROWS)) u_screen (
        .aclk, .cmd, .stat
    );

endmodule

@@ sv/tt_checker.sv @@
module tt_props (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input tt_pkg::out_item_t m_data,
    input logic              m_valid,
    input logic              m_ready
);
    import tt_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped");
    a_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cursor_row < 5'd25)
        else $error("row out of range");
    a_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cursor_column < 7'd80)
        else $error("column out of range");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken early");
endmodule

bind text_terminal_with_csi_cursor_control tt_props u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_data, .m_valid, .m_ready
);
